// ----- sv/bloom_filter_membership_probe_defines.svh -----
// Assertion macros for the bloom filter membership probe.
// Used by the back-end module; no other dependencies.
`ifndef BLOOM_FILTER_MEMBERSHIP_PROBE_DEFINES_SVH
`define BLOOM_FILTER_MEMBERSHIP_PROBE_DEFINES_SVH
`ifndef SYNTHESIS
`define BFMP_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("bfmp assertion failed");
`define BFMP_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("bfmp forbidden condition");
`else
`define BFMP_ASSERT(lbl, prop)
`define BFMP_NEVER(lbl, cond)
`endif
`endif

// ----- sv/bfmp_pkg.sv -----
// Shared types, constants and the FNV-1a step for the bloom filter probe.
// No dependencies.
package bfmp_pkg;
	localparam int DEF_MAX_FILTER_BITS = 65536;
	localparam int DEF_MAX_PROBES = 32;
	localparam int QUEUE_DEPTH = 4;
	localparam int ADDR_W = 13;

	localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
	localparam logic [63:0] GOLDEN_SEED = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] FNV_PRIME_LO = 64'h1B3;
	localparam int FNV_PRIME_SHIFT = 40;

	localparam logic REG_BITS = 1'b0;
	localparam logic REG_PROBES = 1'b1;
	localparam logic [16:0] BITS_RESET = 17'd65536;
	localparam logic [5:0] PROBES_RESET = 6'd7;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_KEY = 1'b1;

	typedef struct packed {
		logic is_write;
		logic [ADDR_W-1:0] addr;
		logic [7:0] data;
		logic [63:0] h1;
		logic [63:0] step;
	} bfmp_entry_t;

	function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
		logic [63:0] x;
		x = h ^ {56'd0, b};
		return (x << FNV_PRIME_SHIFT) + 64'(x * FNV_PRIME_LO);
	endfunction
endpackage

// ----- sv/bfmp_front.sv -----
// Front end: accepts input transactions, runs both FNV-1a hashes and
// queues filter writes and finished key queries. Depends on bfmp_pkg.
module bfmp_front import bfmp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              func,
	input  logic [ADDR_W-1:0] byte_address,
	input  logic [7:0]        filter_byte,
	input  logic [7:0]        key_byte,
	input  logic              byte_present,
	input  logic              key_last,
	input  logic              q_full,
	output logic              push,
	output bfmp_entry_t       push_entry
);
	logic [63:0] hp_q, hs_q, hp_nx, hs_nx;
	logic accept;

	assign in_stall = q_full;
	assign accept = in_valid && !q_full;
	assign hp_nx = byte_present ? fnv_step(hp_q, key_byte) : hp_q;
	assign hs_nx = byte_present ? fnv_step(hs_q, key_byte) : hs_q;
	assign push = accept && (func == FUNC_WRITE || key_last);

	always_comb begin
		push_entry.is_write = (func == FUNC_WRITE);
		push_entry.addr = byte_address;
		push_entry.data = filter_byte;
		push_entry.h1 = hp_nx;
		push_entry.step = hs_nx | 64'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hp_q <= FNV_BASIS;
			hs_q <= FNV_BASIS ^ GOLDEN_SEED;
		end else if (accept && func == FUNC_KEY) begin
			if (key_last) begin
				hp_q <= FNV_BASIS;
				hs_q <= FNV_BASIS ^ GOLDEN_SEED;
			end else begin
				hp_q <= hp_nx;
				hs_q <= hs_nx;
			end
		end
	end
endmodule

// ----- sv/bfmp_queue.sv -----
// Short FIFO between front and back end. Depends on bfmp_pkg.
module bfmp_queue import bfmp_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  bfmp_entry_t push_entry,
	output logic        full,
	output logic        q_valid,
	input  logic        pop,
	output bfmp_entry_t q_entry
);
	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	bfmp_entry_t slots_q [DEPTH];
	logic [IW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic do_push, do_pop;

	assign full = (cnt_q == CW'(DEPTH));
	assign q_valid = (cnt_q != '0);
	assign q_entry = slots_q[rp_q];
	assign do_push = push && !full;
	assign do_pop = pop && q_valid;

	always_ff @(posedge clk) begin
		if (do_push) slots_q[wp_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wp_q <= (wp_q == IW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (do_pop) rp_q <= (rp_q == IW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule

// ----- sv/bfmp_back.sv -----
// Back end: filter store, bit-serial modulo reduction, probe sequencer
// and result register. Depends on bfmp_pkg and the defines header.
`include "bloom_filter_membership_probe_defines.svh"
module bfmp_back import bfmp_pkg::*; #(
	parameter int MAX_FILTER_BITS = DEF_MAX_FILTER_BITS,
	parameter int MAX_PROBES = DEF_MAX_PROBES,
	parameter int NB = $clog2(MAX_FILTER_BITS + 1),
	parameter int PW = $clog2(MAX_PROBES + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  bfmp_entry_t   q_entry,
	output logic          pop,
	input  logic [NB-1:0] nbits,
	input  logic [PW-1:0] nprobes,
	output logic          out_valid,
	input  logic          out_stall,
	output logic          may_contain
);
	localparam int STORE_BYTES = (MAX_FILTER_BITS + 7) / 8;
	localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MOD = 3'd1;
	localparam logic [2:0] ST_READ = 3'd2;
	localparam logic [2:0] ST_CHECK = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [7:0] mem [STORE_BYTES];
	logic [7:0] rdata_q;
	logic [2:0] bitsel_q;
	logic mem_we;
	logic [AW-1:0] mem_ra;

	logic [2:0] state_q;
	logic [5:0] cnt_q;
	logic [63:0] hsh_q, ssh_q, acc_q, step_q;
	logic carry_q;
	logic [NB-1:0] r_q, s_q, w_q;
	logic [NB-1:0] rh_nx, rs_nx, rw_nx, r_adv;
	logic [NB:0] t1, t1r, t2;
	logic [PW-1:0] pidx_q;
	logic res_q, hit_q, out_valid_q, probe_bit;

	function automatic logic [NB-1:0] red(input logic [NB:0] x, input logic [NB-1:0] n);
		return (x >= {1'b0, n}) ? NB'(x - {1'b0, n}) : NB'(x);
	endfunction

	assign rh_nx = red({r_q, hsh_q[63]}, nbits);
	assign rs_nx = red({s_q, ssh_q[63]}, nbits);
	assign rw_nx = red({w_q, 1'b0}, nbits);

	assign t1 = {1'b0, r_q} + {1'b0, s_q};
	assign t1r = (t1 >= {1'b0, nbits}) ? t1 - {1'b0, nbits} : t1;
	assign t2 = (t1r >= {1'b0, w_q}) ? t1r - {1'b0, w_q} : t1r + {1'b0, nbits} - {1'b0, w_q};
	assign r_adv = carry_q ? NB'(t2) : NB'(t1r);

	assign probe_bit = rdata_q[bitsel_q];
	assign pop = (state_q == ST_IDLE) && q_valid;
	assign mem_we = pop && q_entry.is_write && (32'(q_entry.addr) < STORE_BYTES);
	assign mem_ra = AW'(r_q >> 3);
	assign out_valid = out_valid_q;
	assign may_contain = res_q;

	always_ff @(posedge clk) begin
		if (mem_we) mem[AW'(q_entry.addr)] <= q_entry.data;
		rdata_q <= mem[mem_ra];
		bitsel_q <= r_q[2:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			res_q <= 1'b0;
			hit_q <= 1'b0;
			cnt_q <= '0;
			pidx_q <= '0;
			carry_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (pop && !q_entry.is_write) begin
						hsh_q <= q_entry.h1;
						ssh_q <= q_entry.step;
						acc_q <= q_entry.h1;
						step_q <= q_entry.step;
						r_q <= '0;
						s_q <= '0;
						w_q <= (nbits == NB'(1)) ? '0 : NB'(1);
						cnt_q <= '0;
						state_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					r_q <= rh_nx;
					s_q <= rs_nx;
					w_q <= rw_nx;
					hsh_q <= hsh_q << 1;
					ssh_q <= ssh_q << 1;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 6'd63) begin
						pidx_q <= '0;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					{carry_q, acc_q} <= {1'b0, acc_q} + {1'b0, step_q};
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (!probe_bit) begin
						hit_q <= 1'b0;
						state_q <= ST_DONE;
					end else if (pidx_q == nprobes - 1'b1) begin
						hit_q <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						pidx_q <= pidx_q + 1'b1;
						r_q <= r_adv;
						state_q <= ST_READ;
					end
				end
				ST_DONE: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						res_q <= hit_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`BFMP_ASSERT(a_check_after_read, (state_q == ST_CHECK) |-> ($past(state_q) == ST_READ))
	`BFMP_NEVER(a_residue_range, (state_q == ST_READ || state_q == ST_CHECK) && (r_q >= nbits))
	`BFMP_NEVER(a_probe_limit, (state_q == ST_CHECK) && (pidx_q >= nprobes))
	`BFMP_ASSERT(a_result_hold, (out_valid_q && out_stall) |=> (out_valid_q && $stable(res_q)))
endmodule

// ----- sv/bloom_filter_membership_probe.sv -----
// Bloom filter membership probe: APB configuration, front end, queue, back end.
// Depends on bfmp_pkg, bfmp_front, bfmp_queue and bfmp_back.
//
// Input channel (in_valid/in_stall): func = 0 writes filter_byte at byte_address;
// func = 1 delivers a key byte (byte_present) and key_last ends the key.
// Key bytes hash at one per cycle in the front end while in_stall is low;
// filter writes and finished keys enter a four-entry queue, so the front keeps
// taking bytes while the back end probes.
// Output channel (out_valid/out_stall): one may_contain per key, in order.
// Per key the back end dequeues the key, runs the bit-serial modulo reducer
// (h1, step and 2^64 mod filter_bit_count in parallel), then reads and checks
// the filter memory for each probe until a bit is clear, then loads the result
// register. A filter write is stored as it is dequeued.
// Reset restores the hash seeds and the register defaults (65536 bits, 7
// probes); filter contents are undefined until loaded.
// When the receiver stalls, the result holds, the back end waits, the queue
// fills and in_stall rises.
module bloom_filter_membership_probe import bfmp_pkg::*; #(
	parameter int MAX_FILTER_BITS = DEF_MAX_FILTER_BITS,
	parameter int MAX_PROBES = DEF_MAX_PROBES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              func,
	input  logic [ADDR_W-1:0] byte_address,
	input  logic [7:0]        filter_byte,
	input  logic [7:0]        key_byte,
	input  logic              byte_present,
	input  logic              key_last,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              may_contain
);
	localparam int NB = $clog2(MAX_FILTER_BITS + 1);
	localparam int PW = $clog2(MAX_PROBES + 1);

	logic [16:0] bits_q;
	logic [5:0] probes_q;
	logic [NB-1:0] nbits;
	logic [PW-1:0] nprobes;
	logic push, q_full, q_valid, pop;
	bfmp_entry_t push_entry, q_entry;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_PROBES) ? {26'd0, probes_q} : {15'd0, bits_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= BITS_RESET;
			probes_q <= PROBES_RESET;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_BITS) bits_q <= pwdata[16:0];
			else probes_q <= pwdata[5:0];
		end
	end

	always_comb begin
		if (bits_q == '0) nbits = NB'(1);
		else if (32'(bits_q) > MAX_FILTER_BITS) nbits = NB'(MAX_FILTER_BITS);
		else nbits = NB'(bits_q);
		if (probes_q == '0) nprobes = PW'(1);
		else if (32'(probes_q) > MAX_PROBES) nprobes = PW'(MAX_PROBES);
		else nprobes = PW'(probes_q);
	end

	bfmp_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .byte_address(byte_address), .filter_byte(filter_byte),
		.key_byte(key_byte), .byte_present(byte_present), .key_last(key_last),
		.q_full(q_full), .push(push), .push_entry(push_entry)
	);

	bfmp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_entry(push_entry), .full(q_full),
		.q_valid(q_valid), .pop(pop), .q_entry(q_entry)
	);

	bfmp_back #(
		.MAX_FILTER_BITS(MAX_FILTER_BITS), .MAX_PROBES(MAX_PROBES), .NB(NB), .PW(PW)
	) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_entry(q_entry), .pop(pop),
		.nbits(nbits), .nprobes(nprobes),
		.out_valid(out_valid), .out_stall(out_stall), .may_contain(may_contain)
	);
endmodule
